// File: src/cdcs_pkg.sv
// Shared types, constants and BCD helpers for the clock drift compare and sync core.
package cdcs_pkg;

  localparam int EPOCH_LAT   = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [11:0] EPOCH_YEAR         = 12'd1970;
  localparam logic [11:0] BASE_YEAR          = 12'd2000;
  localparam logic [20:0] LEAPS_BEFORE_EPOCH = 21'd477;
  localparam logic [31:0] SECS_PER_DAY       = 32'd86400;
  localparam logic [17:0] SECS_PER_HOUR      = 18'd3600;
  localparam logic [17:0] SECS_PER_MIN       = 18'd60;

  localparam logic [15:0] THRESHOLD_RESET = 16'd2;
  localparam logic        PREFER_RESET    = 1'b1;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_LOAD_LOCAL = 2'd1,
    ACT_WRITE_EXT  = 2'd2,
    ACT_INVALID    = 2'd3
  } action_e;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_PREFER    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]  ext_second;
    logic [6:0]  ext_minute;
    logic [5:0]  ext_hour;
    logic [2:0]  ext_weekday;
    logic [5:0]  ext_day;
    logic [4:0]  ext_month;
    logic [11:0] ext_year;
    logic [5:0]  loc_second;
    logic [5:0]  loc_minute;
    logic [4:0]  loc_hour;
    logic [4:0]  loc_day;
    logic [3:0]  loc_month;
    logic [11:0] loc_year;
    logic        invalid;
    logic        loc_early;
    logic [55:0] write_bcd;
  } item_t;

  function automatic logic [7:0] bcd_dec(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'h0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'h0, b[3:0]};
  endfunction

  function automatic logic [7:0] bcd_enc(input logic [7:0] v);
    logic [15:0] p;
    logic [7:0]  r;
    p = {8'h00, v} * 16'd205;
    r = v - ({3'b000, p[15:11]} * 8'd10);
    return {p[14:11], r[3:0]};
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: src/cdcs_front.sv
// Front stage: accept an item, decode the BCD time, encode the local time, classify.
module cdcs_front import cdcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [55:0] external_raw_i,
  input  logic [5:0]  local_second_i,
  input  logic [5:0]  local_minute_i,
  input  logic [4:0]  local_hour_i,
  input  logic [2:0]  local_weekday_i,
  input  logic [4:0]  local_day_i,
  input  logic [3:0]  local_month_i,
  input  logic [11:0] local_year_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       push_data_o
);

  item_t      item_d;
  item_t      front_q;
  logic       front_vld_q;
  logic       front_vld_d;
  logic       accept;
  logic [7:0] es8, emi8, eh8, ew8, ed8, emo8, ey8;
  logic       ext_bad, loc_bad;

  always_comb begin
    es8  = bcd_dec({1'b0, external_raw_i[6:0]});
    emi8 = bcd_dec({1'b0, external_raw_i[14:8]});
    eh8  = bcd_dec({2'b00, external_raw_i[21:16]});
    ew8  = bcd_dec({5'b00000, external_raw_i[26:24]});
    ed8  = bcd_dec({2'b00, external_raw_i[37:32]});
    emo8 = bcd_dec({3'b000, external_raw_i[44:40]});
    ey8  = bcd_dec(external_raw_i[55:48]);

    item_d.ext_second  = es8[6:0];
    item_d.ext_minute  = emi8[6:0];
    item_d.ext_hour    = eh8[5:0];
    item_d.ext_weekday = ew8[2:0];
    item_d.ext_day     = ed8[5:0];
    item_d.ext_month   = emo8[4:0];
    item_d.ext_year    = BASE_YEAR + {4'h0, ey8};
    item_d.loc_second  = local_second_i;
    item_d.loc_minute  = local_minute_i;
    item_d.loc_hour    = local_hour_i;
    item_d.loc_day     = local_day_i;
    item_d.loc_month   = local_month_i;
    item_d.loc_year    = local_year_i;

    ext_bad = (emo8[4:0] == 5'd0) || (emo8[4:0] > 5'd12);
    loc_bad = (local_year_i >= EPOCH_YEAR) &&
              ((local_month_i == 4'd0) || (local_month_i > 4'd12));
    item_d.invalid   = ext_bad || loc_bad;
    item_d.loc_early = local_year_i < EPOCH_YEAR;

    item_d.write_bcd = {bcd_enc(8'(local_year_i - BASE_YEAR)),
                        bcd_enc({4'h0, local_month_i}),
                        bcd_enc({3'b000, local_day_i}),
                        bcd_enc({5'b00000, local_weekday_i}),
                        bcd_enc({3'b000, local_hour_i}),
                        bcd_enc({2'b00, local_minute_i}),
                        bcd_enc({2'b00, local_second_i})};
  end

  assign in_stall_o  = front_vld_q && full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_o      = front_vld_q && !full_i;
  assign push_data_o = front_q;

  always_comb begin
    front_vld_d = front_vld_q;
    if (accept) begin
      front_vld_d = 1'b1;
    end else if (push_o) begin
      front_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_vld_q <= 1'b0;
    end else begin
      front_vld_q <= front_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_q <= item_d;
    end
  end

endmodule

// File: src/cdcs_queue.sv
// Short queue of classified items between the front stage and the back pipeline.
module cdcs_queue import cdcs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t head_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/cdcs_epoch.sv
// Seven-stage pipeline that turns a calendar date and time into 32-bit epoch seconds.
module cdcs_epoch import cdcs_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [5:0]  day_i,
  input  logic [5:0]  hour_i,
  input  logic [6:0]  minute_i,
  input  logic [6:0]  second_i,
  output logic [31:0] epoch_o
);

  logic [11:0] yr1_q, yr2_q, yr3_q;
  logic [3:0]  mo1_q, mo2_q, mo3_q;
  logic [5:0]  dy1_q, dy2_q, dy3_q;
  logic [17:0] tod1_q, tod2_q, tod3_q, tod4_q, tod5_q, tod6_q;
  logic [5:0]  cap1_q, cap2_q;
  logic [5:0]  c3_q;
  logic        rz3_q;
  logic [20:0] part3_q, dm3_q;
  logic [20:0] days4_q;
  logic [31:0] prod5_q;
  logic [31:0] epoch6_q;

  logic [19:0] cap_prod;
  logic [17:0] tod_d;
  logic [9:0]  q4_2, rem2;
  logic [5:0]  c2;
  logic        rz2;
  logic [9:0]  q4_3, lp3;
  logic        leap3, adj3;
  logic [20:0] part_d, dm_d;

  always_comb begin
    cap_prod = {10'h000, year_i[11:2]} * 20'd655;
    tod_d    = 18'(hour_i) * SECS_PER_HOUR + 18'(minute_i) * SECS_PER_MIN + 18'(second_i);
  end

  always_comb begin
    q4_2 = yr2_q[11:2];
    rem2 = q4_2 - (10'(cap2_q) * 10'd25);
    if (rem2 >= 10'd25) begin
      c2  = cap2_q + 6'd1;
      rz2 = rem2 == 10'd25;
    end else begin
      c2  = cap2_q;
      rz2 = rem2 == 10'd0;
    end
  end

  always_comb begin
    q4_3   = yr3_q[11:2];
    leap3  = (yr3_q[1:0] == 2'b00) && (!rz3_q || (c3_q[1:0] == 2'b00));
    lp3    = q4_3 - 10'(c3_q) + 10'(c3_q >> 2) - 10'(leap3);
    adj3   = leap3 && (mo3_q > 4'd2);
    part_d = 21'(12'(yr3_q - EPOCH_YEAR)) * 21'd365 + 21'(lp3) - LEAPS_BEFORE_EPOCH;
    dm_d   = 21'(month_start(mo3_q)) + 21'(adj3) + 21'(dy3_q) - 21'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yr1_q    <= year_i;
      mo1_q    <= month_i;
      dy1_q    <= day_i;
      tod1_q   <= tod_d;
      cap1_q   <= cap_prod[19:14];

      yr2_q    <= yr1_q;
      mo2_q    <= mo1_q;
      dy2_q    <= dy1_q;
      tod2_q   <= tod1_q;
      cap2_q   <= cap1_q;

      yr3_q    <= yr2_q;
      mo3_q    <= mo2_q;
      dy3_q    <= dy2_q;
      tod3_q   <= tod2_q;
      c3_q     <= c2;
      rz3_q    <= rz2;

      part3_q  <= part_d;
      dm3_q    <= dm_d;
      tod4_q   <= tod3_q;

      days4_q  <= part3_q + dm3_q;
      tod5_q   <= tod4_q;

      prod5_q  <= {{11{days4_q[20]}}, days4_q} * SECS_PER_DAY;
      tod6_q   <= tod5_q;

      epoch6_q <= prod5_q + 32'(tod6_q);
    end
  end

  assign epoch_o = epoch6_q;

endmodule

// File: src/cdcs_back.sv
// Back pipeline: epoch conversion of both dates, absolute difference, sync decision.
module cdcs_back import cdcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  item_t       head_i,
  output logic        pop_o,
  input  logic [15:0] threshold_i,
  input  logic        prefer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [31:0] difference_seconds_o,
  output logic [6:0]  ext_second_o,
  output logic [6:0]  ext_minute_o,
  output logic [5:0]  ext_hour_o,
  output logic [2:0]  ext_weekday_o,
  output logic [5:0]  ext_day_o,
  output logic [4:0]  ext_month_o,
  output logic [11:0] ext_year_o,
  output logic [55:0] write_bcd_o
);

  logic                 en;
  item_t                pipe_q [EPOCH_LAT];
  logic [EPOCH_LAT-1:0] pipe_vld_q;
  logic [31:0]          ext_epoch, loc_epoch, loc_sel;
  logic [31:0]          diff_d, diff_q;
  item_t                dpl_q, opl_q;
  logic                 dvld_q, ovld_q;
  action_e              act_d, act_q;
  logic [31:0]          odiff_d, odiff_q;
  item_t                last;

  assign en    = !ovld_q || !out_stall_i;
  assign pop_o = en && head_valid_i;
  assign last  = pipe_q[EPOCH_LAT-1];

  cdcs_epoch u_ext_epoch (
    .clk_i    (clk_i),
    .en_i     (en),
    .year_i   (head_i.ext_year),
    .month_i  (head_i.ext_month[3:0]),
    .day_i    (head_i.ext_day),
    .hour_i   (head_i.ext_hour),
    .minute_i (head_i.ext_minute),
    .second_i (head_i.ext_second),
    .epoch_o  (ext_epoch)
  );

  cdcs_epoch u_loc_epoch (
    .clk_i    (clk_i),
    .en_i     (en),
    .year_i   (head_i.loc_year),
    .month_i  (head_i.loc_month),
    .day_i    ({1'b0, head_i.loc_day}),
    .hour_i   ({1'b0, head_i.loc_hour}),
    .minute_i ({1'b0, head_i.loc_minute}),
    .second_i ({1'b0, head_i.loc_second}),
    .epoch_o  (loc_epoch)
  );

  always_comb begin
    loc_sel = last.loc_early ? 32'd0 : loc_epoch;
    diff_d  = (ext_epoch > loc_sel) ? ext_epoch - loc_sel : loc_sel - ext_epoch;
  end

  always_comb begin
    act_d   = ACT_NONE;
    odiff_d = diff_q;
    if (dpl_q.invalid) begin
      act_d   = ACT_INVALID;
      odiff_d = 32'd0;
    end else if (diff_q > 32'(threshold_i)) begin
      act_d = prefer_i ? ACT_LOAD_LOCAL : ACT_WRITE_EXT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_vld_q <= '0;
      dvld_q     <= 1'b0;
      ovld_q     <= 1'b0;
    end else if (en) begin
      pipe_vld_q <= {pipe_vld_q[EPOCH_LAT-2:0], head_valid_i};
      dvld_q     <= pipe_vld_q[EPOCH_LAT-1];
      ovld_q     <= dvld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0] <= head_i;
      for (int k = 1; k < EPOCH_LAT; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
      dpl_q   <= last;
      diff_q  <= diff_d;
      opl_q   <= dpl_q;
      act_q   <= act_d;
      odiff_q <= odiff_d;
    end
  end

  assign out_valid_o          = ovld_q;
  assign action_o             = act_q;
  assign difference_seconds_o = odiff_q;
  assign ext_second_o         = opl_q.ext_second;
  assign ext_minute_o         = opl_q.ext_minute;
  assign ext_hour_o           = opl_q.ext_hour;
  assign ext_weekday_o        = opl_q.ext_weekday;
  assign ext_day_o            = opl_q.ext_day;
  assign ext_month_o          = opl_q.ext_month;
  assign ext_year_o           = opl_q.ext_year;
  assign write_bcd_o          = opl_q.write_bcd;

endmodule

// File: src/clock_drift_compare_and_sync_core.sv
// Top level of the clock drift compare and sync core.
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o  | external_raw_i, local_*_i
//  out     | out_valid_o / out_stall_i| action_o, difference_seconds_o, ext_*_o,
//          |                          | write_bcd_o
//  cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One item per cycle sustained when nothing stalls; a result passes through the
//  front register, four-entry queue, seven-stage epoch pipeline, difference stage
//  and output register.
//  Reset clears the handshake state and sets threshold 2 and prefer-external.
//  A stalled output freezes the back pipeline; the queue and the front register
//  absorb up to five items before the input stalls.
module clock_drift_compare_and_sync_core import cdcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [55:0] external_raw_i,
  input  logic [5:0]  local_second_i,
  input  logic [5:0]  local_minute_i,
  input  logic [4:0]  local_hour_i,
  input  logic [2:0]  local_weekday_i,
  input  logic [4:0]  local_day_i,
  input  logic [3:0]  local_month_i,
  input  logic [11:0] local_year_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [31:0] difference_seconds_o,
  output logic [6:0]  ext_second_o,
  output logic [6:0]  ext_minute_o,
  output logic [5:0]  ext_hour_o,
  output logic [2:0]  ext_weekday_o,
  output logic [5:0]  ext_day_o,
  output logic [4:0]  ext_month_o,
  output logic [11:0] ext_year_o,
  output logic [55:0] write_bcd_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic        push, full, empty, pop;
  item_t       push_data, head;
  logic [15:0] threshold_q;
  logic        prefer_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      prefer_q    <= PREFER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: threshold_q <= cfg_data_i;
        CFG_PREFER:    prefer_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cdcs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .external_raw_i  (external_raw_i),
    .local_second_i  (local_second_i),
    .local_minute_i  (local_minute_i),
    .local_hour_i    (local_hour_i),
    .local_weekday_i (local_weekday_i),
    .local_day_i     (local_day_i),
    .local_month_i   (local_month_i),
    .local_year_i    (local_year_i),
    .full_i          (full),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  cdcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  cdcs_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .head_valid_i         (!empty),
    .head_i               (head),
    .pop_o                (pop),
    .threshold_i          (threshold_q),
    .prefer_i             (prefer_q),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .action_o             (action_o),
    .difference_seconds_o (difference_seconds_o),
    .ext_second_o         (ext_second_o),
    .ext_minute_o         (ext_minute_o),
    .ext_hour_o           (ext_hour_o),
    .ext_weekday_o        (ext_weekday_o),
    .ext_day_o            (ext_day_o),
    .ext_month_o          (ext_month_o),
    .ext_year_o           (ext_year_o),
    .write_bcd_o          (write_bcd_o)
  );

endmodule

// File: src/cdcs_checker.sv
// Port-level checker for the clock drift compare and sync core, with its bind.
module cdcs_checker import cdcs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  action_o,
  input logic [31:0] difference_seconds_o,
  input logic [4:0]  ext_month_o,
  input logic [11:0] ext_year_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(action_o) && $stable(difference_seconds_o))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_INVALID) |-> difference_seconds_o == 32'd0)
    else $error("invalid result carries a nonzero difference");

  a_sync_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((action_o == ACT_LOAD_LOCAL) || (action_o == ACT_WRITE_EXT))
      |-> difference_seconds_o != 32'd0)
    else $error("sync requested with zero difference");

  a_bad_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((ext_month_o == 5'd0) || (ext_month_o > 5'd12))
      |-> (action_o == ACT_INVALID) && (ext_year_o >= BASE_YEAR))
    else $error("out-of-range external month not flagged");

endmodule

bind clock_drift_compare_and_sync_core cdcs_checker u_cdcs_checker (.*);
